@@ rtl/fifo_tlb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_tlb_pkg: shared definitions for the FIFO translation buffer
// Operation codes, default sizes and the command bundle that the controller
// sends to the datapath.
// ----------------------------------------------------------------------------
package fifo_tlb_pkg;

   // Fixed widths of the request and response fields.
   localparam int OP_W    = 2;
   localparam int PAGE_W  = 16;
   localparam int FRAME_W = 16;

   // Default sizes of the translation store.
   localparam int ENTRIES_DEF    = 16;
   localparam int PAGE_BITS_DEF  = 16;
   localparam int FRAME_BITS_DEF = 16;

   // Operation codes carried on the op field.
   typedef logic [OP_W-1:0] op_type;
   localparam op_type OP_LOOKUP     = 2'd0;
   localparam op_type OP_INSERT     = 2'd1;
   localparam op_type OP_INVALIDATE = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the request fields on an input transfer
      logic pick;      // search the ring and register the chosen slot
      logic commit;    // update the store and load the response register
   } dp_cmd_type;

endpackage
`default_nettype wire

@@ rtl/fifo_tlb_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_tlb_ctrl: sequencing controller
// Walks each request through a search state and a commit state, owns the
// handshake signals and tells the datapath when to act.
// ----------------------------------------------------------------------------
module fifo_tlb_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output fifo_tlb_pkg::dp_cmd_type     cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MATCH,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;
   logic      req_take;

   // The response register can take a new result when empty or being drained.
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // Requests are taken when idle or in the cycle that finishes the current one.
   assign req_stall = !((state_ff == S_IDLE) || ((state_ff == S_EXEC) && rsp_free));
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   // Commands to the datapath.
   assign cmd.capture = req_take;
   assign cmd.pick    = (state_ff == S_MATCH);
   assign cmd.commit  = (state_ff == S_EXEC) && rsp_free;

   // Next state and response valid.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = req_take ? S_MATCH : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A search cycle is always followed by a commit cycle.
   a_match_then_exec: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MATCH |=> state_ff == S_EXEC)
      else $error("search cycle not followed by commit cycle");

   // Every commit leaves a response waiting.
   a_commit_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit did not load the response register");

   // A new response never overwrites one that is still stalled.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid_ff && rsp_stall))
      else $error("response overwritten while stalled");

endmodule
`default_nettype wire

@@ rtl/fifo_tlb_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_tlb_dp: translation store and search datapath
// Holds the page tags, valid bits, frame memory, ring head and occupancy,
// picks the first slot in ring order and drives the response payload.
// ----------------------------------------------------------------------------
module fifo_tlb_dp #(
   parameter int ENTRIES    = fifo_tlb_pkg::ENTRIES_DEF,
   parameter int PAGE_BITS  = fifo_tlb_pkg::PAGE_BITS_DEF,
   parameter int FRAME_BITS = fifo_tlb_pkg::FRAME_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire fifo_tlb_pkg::dp_cmd_type          cmd,
   input  wire fifo_tlb_pkg::op_type              req_op,
   input  wire logic [fifo_tlb_pkg::PAGE_W-1:0]   req_page_number,
   input  wire logic [fifo_tlb_pkg::FRAME_W-1:0]  req_frame_number,
   output logic                                   rsp_hit,
   output logic [fifo_tlb_pkg::FRAME_W-1:0]       rsp_frame_out
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   // Request registers.
   fifo_tlb_pkg::op_type    op_ff;
   logic [PAGE_BITS-1:0]    page_ff;
   logic [FRAME_BITS-1:0]   frame_ff;

   // Translation state.
   logic [PAGE_BITS-1:0]    tag_ff [ENTRIES];
   logic [FRAME_BITS-1:0]   frame_mem_ff [ENTRIES];
   logic [ENTRIES-1:0]      valid_ff;
   logic [IDX_W-1:0]        head_ff;
   logic [CNT_W-1:0]        occ_ff;

   // Search results.
   logic [IDX_W-1:0]        slot_ff;
   logic                    found_ff;
   logic                    append_ff;
   logic [FRAME_BITS-1:0]   frame_rd_ff;

   // Response payload.
   logic                    hit_ff;
   logic [fifo_tlb_pkg::FRAME_W-1:0] frame_out_ff;

   logic [PAGE_BITS+fifo_tlb_pkg::PAGE_W-1:0]   page_wide;
   logic [FRAME_BITS+fifo_tlb_pkg::FRAME_W-1:0] frame_wide;
   logic [FRAME_BITS+fifo_tlb_pkg::FRAME_W-1:0] frame_rd_wide;
   logic [ENTRIES-1:0]      match_vec;
   logic [ENTRIES-1:0]      search_vec;
   logic [2*ENTRIES-1:0]    rot_wide;
   logic [ENTRIES-1:0]      rot_vec;
   logic [IDX_W-1:0]        first_k;
   logic                    any_set;
   logic [IDX_W:0]          slot_sum;
   logic [IDX_W-1:0]        pick_slot;
   logic                    not_full;
   logic [IDX_W-1:0]        head_next;

   // Fit the request fields to the stored widths.
   assign page_wide     = {{PAGE_BITS{1'b0}}, req_page_number};
   assign frame_wide    = {{FRAME_BITS{1'b0}}, req_frame_number};
   assign frame_rd_wide = {{fifo_tlb_pkg::FRAME_W{1'b0}}, frame_rd_ff};

   // Tag compare in every slot.
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match_vec[i] = valid_ff[i] && (tag_ff[i] == page_ff);
      end
   end

   // Inserts look for empty slots, other operations for matching ones.
   assign search_vec = (op_ff == fifo_tlb_pkg::OP_INSERT) ? ~valid_ff : match_vec;

   // Rotate so that the head sits at bit zero, then take the first set bit.
   assign rot_wide = {search_vec, search_vec} >> head_ff;
   assign rot_vec  = rot_wide[ENTRIES-1:0];
   assign any_set  = |rot_vec;

   always_comb begin
      first_k = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (rot_vec[i]) begin
            first_k = IDX_W'(i);
         end
      end
   end

   // Map the ring offset back to a slot number.
   always_comb begin
      slot_sum = {1'b0, head_ff} + {1'b0, first_k};
      if (slot_sum >= (IDX_W+1)'(ENTRIES)) begin
         slot_sum = slot_sum - (IDX_W+1)'(ENTRIES);
      end
      pick_slot = slot_sum[IDX_W-1:0];
   end

   assign not_full  = occ_ff < CNT_W'(ENTRIES);
   assign head_next = (head_ff == IDX_W'(ENTRIES - 1)) ? '0 : head_ff + IDX_W'(1);

   // Request capture and search result registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_op;
         page_ff  <= page_wide[PAGE_BITS-1:0];
         frame_ff <= frame_wide[FRAME_BITS-1:0];
      end
      if (cmd.pick) begin
         frame_rd_ff <= frame_mem_ff[pick_slot];
         found_ff    <= any_set;
         if (op_ff == fifo_tlb_pkg::OP_INSERT) begin
            append_ff <= not_full && any_set;
            slot_ff   <= (not_full && any_set) ? pick_slot : head_ff;
         end else begin
            append_ff <= 1'b0;
            slot_ff   <= pick_slot;
         end
      end
   end

   // Tag and frame storage, written by inserts.
   always_ff @(posedge clock) begin
      if (cmd.commit && (op_ff == fifo_tlb_pkg::OP_INSERT)) begin
         tag_ff[slot_ff]       <= page_ff;
         frame_mem_ff[slot_ff] <= frame_ff;
      end
   end

   // Valid bits, ring head and occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         head_ff  <= '0;
         occ_ff   <= '0;
      end else if (cmd.commit) begin
         unique case (op_ff)
            fifo_tlb_pkg::OP_INSERT: begin
               valid_ff[slot_ff] <= 1'b1;
               if (append_ff) begin
                  occ_ff <= occ_ff + CNT_W'(1);
               end else begin
                  head_ff <= head_next;
               end
            end
            fifo_tlb_pkg::OP_INVALIDATE: begin
               if (found_ff) begin
                  valid_ff[slot_ff] <= 1'b0;
                  if (occ_ff != '0) begin
                     occ_ff <= occ_ff - CNT_W'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         unique case (op_ff)
            fifo_tlb_pkg::OP_LOOKUP: begin
               hit_ff       <= found_ff;
               frame_out_ff <= found_ff ? frame_rd_wide[fifo_tlb_pkg::FRAME_W-1:0] : '0;
            end
            fifo_tlb_pkg::OP_INVALIDATE: begin
               hit_ff       <= found_ff;
               frame_out_ff <= '0;
            end
            default: begin
               hit_ff       <= 1'b0;
               frame_out_ff <= '0;
            end
         endcase
      end
   end

   assign rsp_hit       = hit_ff;
   assign rsp_frame_out = frame_out_ff;

   // Occupancy always equals the number of valid slots.
   a_occ_tracks_valid: assert property (@(posedge clock) disable iff (reset)
      32'(occ_ff) == $countones(valid_ff))
      else $error("occupancy does not match valid slots");

   // The ring head stays inside the store.
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff < IDX_W'(ENTRIES - 1) || head_ff == IDX_W'(ENTRIES - 1))
      else $error("ring head out of range");

   // An appending insert always lands on a slot that was empty.
   a_append_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && (op_ff == fifo_tlb_pkg::OP_INSERT) && append_ff |-> !valid_ff[slot_ff])
      else $error("append insert hit an occupied slot");

endmodule
`default_nettype wire

@@ rtl/fifo_tlb_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_tlb_top: fully associative translation buffer, FIFO replacement
// A request carries an op (lookup, insert, invalidate), a page number and a
// frame number; every request produces exactly one response with hit and
// frame_out. Both channels transfer when valid is high and stall is low.
// Each request passes through a search step (tag compare and ring-order
// pick) and then a commit step that loads the response register; the commit
// step waits while the output register is full and stalled. A new request
// is taken in the commit cycle of the previous one.
// When the response receiver stalls, the finished result stays in the
// output register; the block still takes one more request and holds it in
// its commit cycle until the output register frees up.
// Reset empties every slot, sets the ring head and occupancy to zero and
// drops any pending response. No clearing pass is needed.
// ----------------------------------------------------------------------------
module fifo_tlb_top #(
   parameter int ENTRIES    = fifo_tlb_pkg::ENTRIES_DEF,
   parameter int PAGE_BITS  = fifo_tlb_pkg::PAGE_BITS_DEF,
   parameter int FRAME_BITS = fifo_tlb_pkg::FRAME_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire fifo_tlb_pkg::op_type              req_op,
   input  wire logic [fifo_tlb_pkg::PAGE_W-1:0]   req_page_number,
   input  wire logic [fifo_tlb_pkg::FRAME_W-1:0]  req_frame_number,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_hit,
   output logic [fifo_tlb_pkg::FRAME_W-1:0]       rsp_frame_out
);

   fifo_tlb_pkg::dp_cmd_type cmd;

   // Sequencing controller.
   fifo_tlb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Translation store and search datapath.
   fifo_tlb_dp #(
      .ENTRIES    (ENTRIES),
      .PAGE_BITS  (PAGE_BITS),
      .FRAME_BITS (FRAME_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_op           (req_op),
      .req_page_number  (req_page_number),
      .req_frame_number (req_frame_number),
      .rsp_hit          (rsp_hit),
      .rsp_frame_out    (rsp_frame_out)
   );

endmodule
`default_nettype wire
